[src/ppff_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form factor package
// Shared widths, selector codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ppff_pkg;

  localparam int MaxIndex   = 15;
  localparam int RotStages  = 24;
  localparam int IdxW       = 5;
  localparam int ShiftW     = 32;
  localparam int LenW       = 31;
  localparam int ProdW      = ShiftW + IdxW;
  localparam int DotW       = ProdW + 1;
  localparam int MagW       = DotW - 1;
  localparam int PhaseW     = 32;
  localparam int CordW      = 33;
  localparam int CoefW      = 32;
  localparam int NumRegs    = 8;

  localparam logic signed [CordW-1:0] CordicX0 = 33'sd652032874;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_LEN3,
    SEL_LEN4,
    SEL_LEN8,
    SEL_LEN11
  } ppff_sel_e;

  localparam logic [31:0] AtanTurns [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage

[src/pseudopotential_form_factor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pseudopotential form factor
// Streams one complex form factor per reciprocal lattice vector.
// ----------------------------------------------------------------------------
// Input transfers on the s_axis group carry Miller indices, a displacement
// and the lattice constant; each gives exactly one result transfer on the
// m_axis group with VS*cos and VA*sin of the phase in Q2.30.
// The user must write the coefficients for squared lengths 3, 4, 8 and 11
// over the APB port only while the stream is idle; the block does not
// enforce it. Reset clears them to zero. The block is one pipeline taking
// a new item every cycle unless the output stalls, with 4 front-end
// stages, 37 remainder stages, 1 wrap stage, 32 fraction stages, 26 CORDIC
// stages, a multiply stage and the output register; the bit-per-stage
// divider sets the depth. When the receiver holds tready low with a result
// waiting, the whole pipeline freezes and s_axis_tready drops; nothing is
// lost or repeated. Reset empties the pipeline and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
module pseudopotential_form_factor_top
  import ppff_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // miller_h, miller_k, miller_l, shift_x, shift_y, shift_z, cell_length
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // real_part, imag_part
  output logic [63:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic en;

  logic [CoefW-1:0] coef_q [NumRegs];

  logic signed [IdxW-1:0]   in_h, in_k, in_l, cl_h, cl_k, cl_l;
  logic [LenW-1:0]          in_len;
  logic [9:0]               len_sq;
  ppff_sel_e                sel_d;

  logic                     s0_valid_q;
  ppff_sel_e                s0_sel_q;
  logic signed [IdxW-1:0]   s0_h_q, s0_k_q, s0_l_q;
  logic signed [ShiftW-1:0] s0_x_q, s0_y_q, s0_z_q;
  logic [LenW-1:0]          s0_len_q;

  logic                     s1_valid_q;
  ppff_sel_e                s1_sel_q;
  logic signed [ProdW-1:0]  s1_px_q, s1_py_q, s1_pz_q;
  logic [LenW-1:0]          s1_len_q;

  logic                     s2_valid_q;
  ppff_sel_e                s2_sel_q;
  logic signed [DotW-1:0]   s2_dot_q;
  logic [LenW-1:0]          s2_len_q;

  logic                     s3_valid_q;
  ppff_sel_e                s3_sel_q;
  logic                     s3_neg_q;
  logic [MagW-1:0]          s3_mag_q;
  logic [LenW-1:0]          s3_len_q;
  logic [DotW-1:0]          dot_abs;

  logic                     dv_valid;
  ppff_sel_e                dv_sel;
  logic [PhaseW-1:0]        dv_phase;

  logic                     cr_valid;
  ppff_sel_e                cr_sel;
  logic signed [CordW-1:0]  cr_cos, cr_sin;

  logic signed [CoefW-1:0]  vs, va;
  logic                     mp_valid_q;
  logic signed [64:0]       mp_re_q, mp_im_q;

  logic [31:0]              sat_re, sat_im;
  logic                     out_valid_q;
  logic [31:0]              out_re_q, out_im_q;

  function automatic logic signed [IdxW-1:0] clamp_idx(logic signed [IdxW-1:0] v);
    logic signed [IdxW:0] w;
    w = IdxW'(v) == v ? (IdxW+1)'(v) : (IdxW+1)'(v);
    if (w > (IdxW+1)'(MaxIndex)) begin
      return IdxW'(MaxIndex);
    end else if (w < -(IdxW+1)'(MaxIndex)) begin
      return IdxW'(-MaxIndex);
    end
    return v;
  endfunction

  function automatic logic [9:0] square_idx(logic signed [IdxW-1:0] v);
    logic signed [9:0] w;
    w = 10'(v);
    return 10'(w * w);
  endfunction

  function automatic logic [31:0] round_sat(logic signed [64:0] p);
    logic signed [65:0] r;
    r = (66'(p) + 66'sd536870912) >>> 30;
    if (r > 66'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (r < -66'sd2147483648) begin
      return 32'h8000_0000;
    end
    return r[31:0];
  endfunction

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Configuration registers.
  assign pready = 1'b1;
  assign prdata = coef_q[paddr[4:2]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegs; r++) begin
        coef_q[r] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      coef_q[paddr[4:2]] <= pwdata;
    end
  end

  // Stage 0: index clamp, parity and squared-length decode.
  assign in_h   = s_axis_tdata[4:0];
  assign in_k   = s_axis_tdata[9:5];
  assign in_l   = s_axis_tdata[14:10];
  assign in_len = s_axis_tdata[141:111];
  assign cl_h   = clamp_idx(in_h);
  assign cl_k   = clamp_idx(in_k);
  assign cl_l   = clamp_idx(in_l);
  assign len_sq = square_idx(cl_h) + square_idx(cl_k) + square_idx(cl_l);

  always_comb begin
    sel_d = SEL_NONE;
    if ((cl_h[0] == cl_k[0]) && (cl_k[0] == cl_l[0])) begin
      case (len_sq)
        10'd3:   sel_d = SEL_LEN3;
        10'd4:   sel_d = SEL_LEN4;
        10'd8:   sel_d = SEL_LEN8;
        10'd11:  sel_d = SEL_LEN11;
        default: sel_d = SEL_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= s_axis_tvalid;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  assign dot_abs = s2_dot_q[DotW-1] ? -s2_dot_q : s2_dot_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_sel_q <= sel_d;
      s0_h_q   <= cl_h;
      s0_k_q   <= cl_k;
      s0_l_q   <= cl_l;
      s0_x_q   <= s_axis_tdata[46:15];
      s0_y_q   <= s_axis_tdata[78:47];
      s0_z_q   <= s_axis_tdata[110:79];
      s0_len_q <= (in_len == '0) ? LenW'(1) : in_len;

      s1_sel_q <= s0_sel_q;
      s1_px_q  <= ProdW'(s0_x_q) * ProdW'(s0_h_q);
      s1_py_q  <= ProdW'(s0_y_q) * ProdW'(s0_k_q);
      s1_pz_q  <= ProdW'(s0_z_q) * ProdW'(s0_l_q);
      s1_len_q <= s0_len_q;

      s2_sel_q <= s1_sel_q;
      s2_dot_q <= DotW'(s1_px_q) + DotW'(s1_py_q) + DotW'(s1_pz_q);
      s2_len_q <= s1_len_q;

      s3_sel_q <= s2_sel_q;
      s3_neg_q <= s2_dot_q[DotW-1];
      s3_mag_q <= dot_abs[MagW-1:0];
      s3_len_q <= s2_len_q;
    end
  end

  ppff_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_valid_q),
    .sel_i   (s3_sel_q),
    .neg_i   (s3_neg_q),
    .mag_i   (s3_mag_q),
    .div_i   (s3_len_q),
    .valid_o (dv_valid),
    .sel_o   (dv_sel),
    .phase_o (dv_phase)
  );

  ppff_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .sel_i   (dv_sel),
    .phase_i (dv_phase),
    .valid_o (cr_valid),
    .sel_o   (cr_sel),
    .cos_o   (cr_cos),
    .sin_o   (cr_sin)
  );

  always_comb begin
    unique case (cr_sel)
      SEL_LEN3: begin
        vs = coef_q[0];
        va = coef_q[4];
      end
      SEL_LEN4: begin
        vs = coef_q[1];
        va = coef_q[5];
      end
      SEL_LEN8: begin
        vs = coef_q[2];
        va = coef_q[6];
      end
      SEL_LEN11: begin
        vs = coef_q[3];
        va = coef_q[7];
      end
      default: begin
        vs = '0;
        va = '0;
      end
    endcase
  end

  assign sat_re = round_sat(mp_re_q);
  assign sat_im = round_sat(mp_im_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      mp_valid_q  <= cr_valid;
      out_valid_q <= mp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mp_re_q  <= 65'(vs) * 65'(cr_cos);
      mp_im_q  <= 65'(va) * 65'(cr_sin);
      out_re_q <= sat_re;
      out_im_q <= sat_im;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_im_q, out_re_q};

endmodule

[src/ppff_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase divider
// Pipelined restoring division: reduces the dot product modulo the cell
// length, then forms the 32-bit fraction of a turn, one bit per stage.
// ----------------------------------------------------------------------------
module ppff_divider
  import ppff_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ppff_sel_e         sel_i,
  input  logic              neg_i,
  input  logic [MagW-1:0]   mag_i,
  input  logic [LenW-1:0]   div_i,
  output logic              valid_o,
  output ppff_sel_e         sel_o,
  output logic [PhaseW-1:0] phase_o
);

  logic              m_valid [0:MagW];
  ppff_sel_e         m_sel   [0:MagW];
  logic              m_neg   [0:MagW];
  logic [MagW-1:0]   m_mag   [0:MagW];
  logic [LenW-1:0]   m_div   [0:MagW];
  logic [LenW-1:0]   m_rem   [0:MagW];

  logic              f_valid [0:PhaseW];
  ppff_sel_e         f_sel   [0:PhaseW];
  logic [LenW-1:0]   f_div   [0:PhaseW];
  logic [LenW-1:0]   f_rem   [0:PhaseW];
  logic [PhaseW-1:0] f_quo   [0:PhaseW];

  logic [LenW-1:0]   fix_rem_d;

  assign m_valid[0] = valid_i;
  assign m_sel[0]   = sel_i;
  assign m_neg[0]   = neg_i;
  assign m_mag[0]   = mag_i;
  assign m_div[0]   = div_i;
  assign m_rem[0]   = '0;

  for (genvar j = 0; j < MagW; j++) begin : g_mod
    logic [LenW:0] trial;
    logic [LenW:0] diff;
    logic [LenW-1:0] rem_d;

    always_comb begin
      trial = {m_rem[j], m_mag[j][MagW-1-j]};
      diff  = trial - {1'b0, m_div[j]};
      rem_d = (trial >= {1'b0, m_div[j]}) ? diff[LenW-1:0] : trial[LenW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m_valid[j+1] <= 1'b0;
      end else if (en_i) begin
        m_valid[j+1] <= m_valid[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_sel[j+1] <= m_sel[j];
        m_neg[j+1] <= m_neg[j];
        m_mag[j+1] <= m_mag[j];
        m_div[j+1] <= m_div[j];
        m_rem[j+1] <= rem_d;
      end
    end
  end

  // A negative dot product with a nonzero remainder wraps to the divisor minus that remainder.
  assign fix_rem_d = (m_neg[MagW] && (m_rem[MagW] != '0)) ?
                     m_div[MagW] - m_rem[MagW] : m_rem[MagW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid[0] <= 1'b0;
    end else if (en_i) begin
      f_valid[0] <= m_valid[MagW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_sel[0] <= m_sel[MagW];
      f_div[0] <= m_div[MagW];
      f_rem[0] <= fix_rem_d;
      f_quo[0] <= '0;
    end
  end

  for (genvar k = 0; k < PhaseW; k++) begin : g_frac
    logic [LenW:0] trial;
    logic [LenW:0] diff;
    logic          ge;

    always_comb begin
      trial = {f_rem[k], 1'b0};
      diff  = trial - {1'b0, f_div[k]};
      ge    = (trial >= {1'b0, f_div[k]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        f_valid[k+1] <= 1'b0;
      end else if (en_i) begin
        f_valid[k+1] <= f_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_sel[k+1] <= f_sel[k];
        f_div[k+1] <= f_div[k];
        f_rem[k+1] <= ge ? diff[LenW-1:0] : trial[LenW-1:0];
        f_quo[k+1] <= {f_quo[k][PhaseW-2:0], ge};
      end
    end
  end

  assign valid_o = f_valid[PhaseW];
  assign sel_o   = f_sel[PhaseW];
  assign phase_o = f_quo[PhaseW];

endmodule

[src/ppff_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine and cosine unit
// Quarter-turn split, a pipelined rotation-mode CORDIC and the exact
// quadrant fold.
// ----------------------------------------------------------------------------
module ppff_cordic
  import ppff_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  ppff_sel_e               sel_i,
  input  logic [PhaseW-1:0]       phase_i,
  output logic                    valid_o,
  output ppff_sel_e               sel_o,
  output logic signed [CordW-1:0] cos_o,
  output logic signed [CordW-1:0] sin_o
);

  logic                    c_valid [0:RotStages];
  ppff_sel_e               c_sel   [0:RotStages];
  logic [1:0]              c_quad  [0:RotStages];
  logic signed [CordW-1:0] c_x     [0:RotStages];
  logic signed [CordW-1:0] c_y     [0:RotStages];
  logic signed [CordW-1:0] c_z     [0:RotStages];

  logic [PhaseW-1:0]       shifted;
  logic                    valid_q;
  ppff_sel_e               sel_q;
  logic signed [CordW-1:0] cos_d, sin_d, cos_q, sin_q;

  assign shifted = phase_i + PhaseW'(32'h2000_0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid[0] <= 1'b0;
    end else if (en_i) begin
      c_valid[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_sel[0]  <= sel_i;
      c_quad[0] <= shifted[31:30];
      c_x[0]    <= CordicX0;
      c_y[0]    <= '0;
      c_z[0]    <= signed'(CordW'(shifted[29:0])) - signed'(CordW'(32'h2000_0000));
    end
  end

  for (genvar i = 0; i < RotStages; i++) begin : g_rot
    logic signed [CordW-1:0] dx, dy, da;

    always_comb begin
      dx = c_y[i] >>> i;
      dy = c_x[i] >>> i;
      da = signed'(CordW'(AtanTurns[i]));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_valid[i+1] <= 1'b0;
      end else if (en_i) begin
        c_valid[i+1] <= c_valid[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_sel[i+1]  <= c_sel[i];
        c_quad[i+1] <= c_quad[i];
        if (!c_z[i][CordW-1]) begin
          c_x[i+1] <= c_x[i] - dx;
          c_y[i+1] <= c_y[i] + dy;
          c_z[i+1] <= c_z[i] - da;
        end else begin
          c_x[i+1] <= c_x[i] + dx;
          c_y[i+1] <= c_y[i] - dy;
          c_z[i+1] <= c_z[i] + da;
        end
      end
    end
  end

  always_comb begin
    case (c_quad[RotStages])
      2'd0: begin
        cos_d = c_x[RotStages];
        sin_d = c_y[RotStages];
      end
      2'd1: begin
        cos_d = -c_y[RotStages];
        sin_d = c_x[RotStages];
      end
      2'd2: begin
        cos_d = -c_x[RotStages];
        sin_d = -c_y[RotStages];
      end
      default: begin
        cos_d = c_y[RotStages];
        sin_d = -c_x[RotStages];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= c_valid[RotStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q <= c_sel[RotStages];
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign valid_o = valid_q;
  assign sel_o   = sel_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule
